// File: rtl/mcett_pkg.sv
// Shared types, constants and helpers for the event timer table.
`timescale 1ns / 1ps
package mcett_pkg;

    localparam int TIMER_SLOTS_DEF = 16;

    localparam int OP_W     = 2;
    localparam int ID_W     = 16;
    localparam int UNITS_W  = 20;
    localparam int EVK_W    = 2;
    localparam int ELAPSED_W = 32;
    localparam int RKIND_W  = 3;
    localparam int SCALED_W = 40;
    localparam int CNT_W    = 48;
    localparam int BASE_W   = 64;

    localparam logic [UNITS_W-1:0] UNIT_SCALE = UNITS_W'(1000000);

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // event kinds held per timer
    localparam logic [EVK_W-1:0] EVK_NONE     = 2'd0;
    localparam logic [EVK_W-1:0] EVK_PERIODIC = 2'd1;
    localparam logic [EVK_W-1:0] EVK_ANIM     = 2'd2;
    localparam logic [EVK_W-1:0] EVK_EXPIRE   = 2'd3;

    // result kinds
    localparam logic [RKIND_W-1:0] RK_ADDED     = 3'd0;
    localparam logic [RKIND_W-1:0] RK_FULL      = 3'd1;
    localparam logic [RKIND_W-1:0] RK_REJECTED  = 3'd2;
    localparam logic [RKIND_W-1:0] RK_RESET     = 3'd3;
    localparam logic [RKIND_W-1:0] RK_PERIODIC  = 3'd4;
    localparam logic [RKIND_W-1:0] RK_ANIM      = 3'd5;
    localparam logic [RKIND_W-1:0] RK_EXPIRE    = 3'd6;
    localparam logic [RKIND_W-1:0] RK_TICK_DONE = 3'd7;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [EVK_W-1:0]    kind;
        logic [SCALED_W-1:0] duration;
        logic [SCALED_W-1:0] period;
        logic [CNT_W-1:0]    count;
        logic [CNT_W-1:0]    period_count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // 48-bit counter plus elapsed time, clamped at all ones
    function automatic logic [CNT_W-1:0] sat_add48(input logic [CNT_W-1:0] a,
                                                   input logic [ELAPSED_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W + 1 - ELAPSED_W){1'b0}}, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

// File: rtl/mcett_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mcett_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/multi_channel_event_timer_table_core.sv
// Top level of the event timer table: sequencer, slot walk and result register.
`timescale 1ns / 1ps
// Add or table reset: accepted in idle; the ADD or CLEAR state then loads the result register.
// Tick over N timers: setup and first read, then per timer a RAM read and a compare and
//   write-back, then tick done, which loads the result register and returns to idle.
// Output stalls can hold any step that emits a result. A new item is accepted only in idle.
//   The tick's pace is set by the single read port and the read-modify-write per slot.
// aresetn (synchronous, active low) clears the timer count, base time, sequencer and
//   output valid; the timer RAM keeps its contents, as no slot at or above the count is read.
module multi_channel_event_timer_table_core #(
    parameter int TIMER_SLOTS = mcett_pkg::TIMER_SLOTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [mcett_pkg::OP_W-1:0]         s_operation,
    input  logic [mcett_pkg::ID_W-1:0]         s_timer_id,
    input  logic [mcett_pkg::UNITS_W-1:0]      s_duration_units,
    input  logic [mcett_pkg::UNITS_W-1:0]      s_period_units,
    input  logic [mcett_pkg::EVK_W-1:0]        s_event_kind,
    input  logic [mcett_pkg::ELAPSED_W-1:0]    s_elapsed,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [mcett_pkg::RKIND_W-1:0]      m_result_kind,
    output logic [mcett_pkg::ID_W-1:0]         m_event_timer_id,
    output logic [mcett_pkg::CNT_W-1:0]        m_progress,
    output logic [mcett_pkg::CNT_W-1:0]        m_span,
    output logic [mcett_pkg::BASE_W-1:0]       m_base_time,
    output logic                               m_last
);

    import mcett_pkg::*;

    // slot address and count widths
    localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(TIMER_SLOTS);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ADD   = 3'd1;
    localparam logic [2:0] ST_CLEAR = 3'd2;
    localparam logic [2:0] ST_TRD   = 3'd3;   // tick setup, first read
    localparam logic [2:0] ST_TS1   = 3'd4;   // read data in, saturating sums
    localparam logic [2:0] ST_TS2   = 3'd5;   // compares, event, write-back
    localparam logic [2:0] ST_TDONE = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [CW-1:0]        used_reg, used_next;
    logic [BASE_W-1:0]    acc_reg, acc_next;
    logic [CW-1:0]        rd_idx_reg, rd_idx_next;    // slot being read
    logic [CW-1:0]        wr_idx_reg, wr_idx_next;    // compacted write slot

    // captured input item
    logic [ID_W-1:0]      id_reg;
    logic [UNITS_W-1:0]   dur_u_reg;
    logic [UNITS_W-1:0]   per_u_reg;
    logic [EVK_W-1:0]     kind_reg;
    logic [ELAPSED_W-1:0] el_reg;

    // slot under work
    entry_t               ent_reg;
    logic [CNT_W-1:0]     pc_sum_reg;
    logic [CNT_W-1:0]     cnt_sum_reg;

    // result register
    logic                 m_valid_reg, m_valid_next;
    logic [RKIND_W-1:0]   m_kind_reg;
    logic [ID_W-1:0]      m_id_reg;
    logic [CNT_W-1:0]     m_prog_reg;
    logic [CNT_W-1:0]     m_span_reg;
    logic [BASE_W-1:0]    m_base_reg;
    logic                 m_last_reg;

    // RAM port
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    entry_t               ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    // emit request towards the result register
    logic                 emit;
    logic [RKIND_W-1:0]   emit_kind;
    logic [ID_W-1:0]      emit_id;
    logic [CNT_W-1:0]     emit_prog;
    logic [CNT_W-1:0]     emit_span;
    logic [BASE_W-1:0]    emit_base;
    logic                 emit_last;

    logic                 out_free;
    logic                 accept;

    // scaled add values
    logic [SCALED_W-1:0]  dur_scaled;
    logic [SCALED_W-1:0]  per_scaled;

    // slot evaluation
    logic [CNT_W-1:0]     per48, dur48, pc_new, anim_val;
    logic                 pc_ge, expired, ev_per, ev_anim, ev_exp, need_ev;
    logic [CW-1:0]        rd_idx_inc;
    entry_t               ent_rd;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign dur_scaled = SCALED_W'(dur_u_reg) * SCALED_W'(UNIT_SCALE);
    assign per_scaled = SCALED_W'(per_u_reg) * SCALED_W'(UNIT_SCALE);

    assign ent_rd = entry_t'(ram_rdata);

    assign per48    = {{(CNT_W - SCALED_W){1'b0}}, ent_reg.period};
    assign dur48    = {{(CNT_W - SCALED_W){1'b0}}, ent_reg.duration};
    assign pc_ge    = (pc_sum_reg >= per48);
    assign pc_new   = pc_ge ? (pc_sum_reg - per48) : pc_sum_reg;
    assign anim_val = (cnt_sum_reg > dur48) ? dur48 : cnt_sum_reg;
    assign expired  = (ent_reg.duration != '0) && (cnt_sum_reg >= dur48);
    assign ev_per   = (ent_reg.kind == EVK_PERIODIC) && pc_ge;
    assign ev_anim  = (ent_reg.kind == EVK_ANIM);
    assign ev_exp   = (ent_reg.kind == EVK_EXPIRE) && expired;
    assign need_ev  = ev_per || ev_anim || ev_exp;
    assign rd_idx_inc = rd_idx_reg + CW'(1);

    always_comb begin
        state_next  = state_reg;
        used_next   = used_reg;
        acc_next    = acc_reg;
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;

        ram_we    = 1'b0;
        ram_waddr = wr_idx_reg[AW-1:0];
        ram_wdata = ent_reg;
        ram_re    = 1'b0;
        ram_raddr = rd_idx_reg[AW-1:0];

        emit      = 1'b0;
        emit_kind = RK_ADDED;
        emit_id   = '0;
        emit_prog = '0;
        emit_span = '0;
        emit_base = '0;
        emit_last = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_operation)
                        OP_ADD:   state_next = ST_ADD;
                        OP_TICK:  state_next = ST_TRD;
                        OP_CLEAR: state_next = ST_CLEAR;
                        default:  state_next = ST_IDLE;   // unused code, dropped
                    endcase
                end
            end
            ST_ADD: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_id   = id_reg;
                    emit_last = 1'b1;
                    priority if ((kind_reg == EVK_EXPIRE) && (dur_u_reg == '0)) begin
                        emit_kind = RK_REJECTED;
                    end else if (used_reg >= SLOTS_C) begin
                        emit_kind = RK_FULL;
                    end else begin
                        emit_kind = RK_ADDED;
                        ram_we    = 1'b1;
                        ram_waddr = used_reg[AW-1:0];
                        ram_wdata = '{id: id_reg, kind: kind_reg, duration: dur_scaled,
                                      period: per_scaled, count: '0, period_count: '0};
                        used_next = used_reg + CW'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_kind  = RK_RESET;
                    emit_last  = 1'b1;
                    used_next  = '0;
                    acc_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_TRD: begin
                acc_next    = acc_reg + {{(BASE_W - ELAPSED_W){1'b0}}, el_reg};
                rd_idx_next = '0;
                wr_idx_next = '0;
                if (used_reg != '0) begin
                    ram_re     = 1'b1;
                    ram_raddr  = '0;
                    state_next = ST_TS1;
                end else begin
                    state_next = ST_TDONE;
                end
            end
            ST_TS1: begin
                state_next = ST_TS2;
            end
            ST_TS2: begin
                // hold the slot until its event, if any, fits in the result register
                if (!need_ev || out_free) begin
                    if (need_ev) begin
                        emit    = 1'b1;
                        emit_id = ent_reg.id;
                        priority if (ev_per) begin
                            emit_kind = RK_PERIODIC;
                            emit_prog = pc_new;
                            emit_span = per48;
                        end else if (ev_anim) begin
                            emit_kind = RK_ANIM;
                            emit_prog = anim_val;
                            emit_span = dur48;
                        end else begin
                            emit_kind = RK_EXPIRE;
                        end
                    end
                    // survivors are written back packed towards slot 0
                    if (!expired) begin
                        ram_we    = 1'b1;
                        ram_waddr = wr_idx_reg[AW-1:0];
                        ram_wdata = '{id: ent_reg.id, kind: ent_reg.kind,
                                      duration: ent_reg.duration, period: ent_reg.period,
                                      count: cnt_sum_reg, period_count: pc_new};
                        wr_idx_next = wr_idx_reg + CW'(1);
                    end
                    rd_idx_next = rd_idx_inc;
                    if (rd_idx_inc < used_reg) begin
                        ram_re     = 1'b1;
                        ram_raddr  = rd_idx_inc[AW-1:0];
                        state_next = ST_TS1;
                    end else begin
                        state_next = ST_TDONE;
                    end
                end
            end
            ST_TDONE: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_kind  = RK_TICK_DONE;
                    emit_base  = acc_reg;
                    emit_last  = 1'b1;
                    used_next  = wr_idx_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            acc_reg     <= '0;
            rd_idx_reg  <= '0;
            wr_idx_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            acc_reg     <= acc_next;
            rd_idx_reg  <= rd_idx_next;
            wr_idx_reg  <= wr_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            id_reg    <= s_timer_id;
            dur_u_reg <= s_duration_units;
            per_u_reg <= s_period_units;
            kind_reg  <= s_event_kind;
            el_reg    <= s_elapsed;
        end
        if (state_reg == ST_TS1) begin
            ent_reg     <= ent_rd;
            pc_sum_reg  <= sat_add48(ent_rd.period_count, el_reg);
            cnt_sum_reg <= sat_add48(ent_rd.count, el_reg);
        end
        if (emit) begin
            m_kind_reg <= emit_kind;
            m_id_reg   <= emit_id;
            m_prog_reg <= emit_prog;
            m_span_reg <= emit_span;
            m_base_reg <= emit_base;
            m_last_reg <= emit_last;
        end
    end

    mcett_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (TIMER_SLOTS),
        .ADDR_W (AW)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_valid          = m_valid_reg;
    assign m_result_kind    = m_kind_reg;
    assign m_event_timer_id = m_id_reg;
    assign m_progress       = m_prog_reg;
    assign m_span           = m_span_reg;
    assign m_base_time      = m_base_reg;
    assign m_last           = m_last_reg;

    // checks
    // compaction must never overtake the read pointer
    a_wr_behind_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TS2) |-> (wr_idx_reg <= rd_idx_reg))
        else $error("write slot ahead of read slot");

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= SLOTS_C)
        else $error("timer count beyond table size");

    // a result never gets overwritten while still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

    // a tick never grows the table
    a_tick_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TDONE && out_free) |=> (used_reg <= $past(used_reg)))
        else $error("tick increased timer count");

endmodule
